// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sphere-plane resolver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Consequent must hold after the antecedent, delayed by dly.
`define ASSERT_AFTER(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("delayed check failed");

`endif

// ===== rtl/spcr_pkg.sv =====
// Shared types, constants and helpers for the sphere-plane resolver.
// No dependencies; used by every spcr_* module and the top level.
package spcr_pkg;

   localparam int unsigned ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_RADIUS      = 2'd0,
      REG_RESTITUTION = 2'd1,
      REG_FRICTION    = 2'd2
   } reg_idx_type;

   localparam logic [30:0] RADIUS_RESET = 31'd65536;
   localparam logic [16:0] RESTIT_RESET = 17'd32768;
   localparam logic [16:0] FRICT_RESET  = 17'd6554;
   localparam logic [16:0] Q16_ONE      = 17'd65536;
   localparam logic signed [31:0] UNIT_ONE = 32'sd1073741824;

   localparam int unsigned FRONT_STAGES = 4;
   localparam int unsigned RESP_STAGES  = 9;
   localparam int unsigned SQRT_STEPS   = 32;
   localparam int unsigned DIV_STEPS    = 31;
   localparam int unsigned STEP_BITS_DEFAULT = 2;

   // Per-transaction data carried alongside the normal computation.
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][32:0] diff;
      logic [2:0]       neg;
      logic             zero;
   } carry_type;

   typedef struct packed {
      carry_type        c;
      logic [2:0][31:0] m;
   } pipe_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/spcr_front.sv =====
// Front end: input capture, normal magnitude scaling and sum of squares.
// Depends on spcr_pkg.
module spcr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [2:0][31:0]     in_pos,
   input  logic [2:0][31:0]     in_vel,
   input  logic [2:0][31:0]     in_pt,
   input  logic [2:0][31:0]     in_raw,
   output logic                 out_valid,
   output spcr_pkg::pipe_type   out_pipe,
   output logic [63:0]          out_sum
);

   // stage 1: magnitudes, largest magnitude, position difference
   logic                 f1_valid_ff;
   spcr_pkg::carry_type  f1_c_ff, f1_c_in;
   logic [2:0][31:0]     f1_m_ff, f1_m_in;
   logic [31:0]          f1_top_ff, f1_top_in;

   always_comb begin
      f1_c_in.pos  = in_pos;
      f1_c_in.vel  = in_vel;
      f1_c_in.zero = 1'b0;
      f1_top_in    = '0;
      for (int i = 0; i < 3; i++) begin
         f1_c_in.diff[i] = 33'($signed(in_pos[i])) - 33'($signed(in_pt[i]));
         f1_c_in.neg[i]  = in_raw[i][31];
         f1_m_in[i]      = in_raw[i][31] ? (~in_raw[i] + 32'd1) : in_raw[i];
         if (f1_m_in[i] > f1_top_in) f1_top_in = f1_m_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f1_valid_ff <= 1'b0;
      else f1_valid_ff <= in_valid;
      f1_c_ff   <= f1_c_in;
      f1_m_ff   <= f1_m_in;
      f1_top_ff <= f1_top_in;
   end

   // stage 2: shift all components so the largest reaches bit 30 (or stays at bit 31)
   logic                 f2_valid_ff;
   spcr_pkg::carry_type  f2_c_ff, f2_c_in;
   logic [2:0][31:0]     f2_m_ff, f2_m_in;
   logic [4:0]           msb;
   logic [4:0]           shamt;

   always_comb begin
      msb = '0;
      for (int b = 0; b < 32; b++) begin
         if (f1_top_ff[b]) msb = 5'(b);
      end
      shamt = (msb >= 5'd30) ? 5'd0 : 5'(5'd30 - msb);
      f2_c_in      = f1_c_ff;
      f2_c_in.zero = (f1_top_ff == '0);
      for (int i = 0; i < 3; i++) f2_m_in[i] = f1_m_ff[i] << shamt;
   end

   always_ff @(posedge clock) begin
      if (reset) f2_valid_ff <= 1'b0;
      else f2_valid_ff <= f1_valid_ff;
      f2_c_ff <= f2_c_in;
      f2_m_ff <= f2_m_in;
   end

   // stage 3: squares
   logic                 f3_valid_ff;
   spcr_pkg::pipe_type   f3_p_ff;
   logic [2:0][63:0]     f3_sq_ff, f3_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) f3_sq_in[i] = 64'(f2_m_ff[i]) * 64'(f2_m_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) f3_valid_ff <= 1'b0;
      else f3_valid_ff <= f2_valid_ff;
      f3_p_ff.c <= f2_c_ff;
      f3_p_ff.m <= f2_m_ff;
      f3_sq_ff  <= f3_sq_in;
   end

   // stage 4: sum of squares (fits 64 bits, max 3 * 2^62)
   logic                 f4_valid_ff;
   spcr_pkg::pipe_type   f4_p_ff;
   logic [63:0]          f4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) f4_valid_ff <= 1'b0;
      else f4_valid_ff <= f3_valid_ff;
      f4_p_ff   <= f3_p_ff;
      f4_sum_ff <= f3_sq_ff[0] + f3_sq_ff[1] + f3_sq_ff[2];
   end

   assign out_valid = f4_valid_ff;
   assign out_pipe  = f4_p_ff;
   assign out_sum   = f4_sum_ff;

endmodule

// ===== rtl/spcr_sqrt.sv =====
// Pipelined restoring integer square root, STEP_BITS result bits per stage.
// Depends on spcr_pkg.
module spcr_sqrt #(
   parameter int unsigned STEP_BITS = spcr_pkg::STEP_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  spcr_pkg::pipe_type   in_pipe,
   input  logic [63:0]          in_sum,
   output logic                 out_valid,
   output spcr_pkg::pipe_type   out_pipe,
   output logic [31:0]          out_len
);

   localparam int unsigned NST = (spcr_pkg::SQRT_STEPS + STEP_BITS - 1) / STEP_BITS;

   typedef struct packed {
      logic [63:0] x;
      logic [33:0] rem;
      logic [31:0] root;
   } sq_st_type;

   logic                valid_ff [NST];
   sq_st_type           st_ff    [NST];
   spcr_pkg::pipe_type  pipe_ff  [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic               cur_valid;
      sq_st_type          cur;
      sq_st_type          st_in;
      spcr_pkg::pipe_type cur_pipe;

      if (s == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur       = '{x: in_sum, rem: '0, root: '0};
         assign cur_pipe  = in_pipe;
      end else begin : g_rest
         assign cur_valid = valid_ff[s-1];
         assign cur       = st_ff[s-1];
         assign cur_pipe  = pipe_ff[s-1];
      end

      always_comb begin : step
         logic [35:0] r_sh;
         logic [35:0] trial;
         r_sh  = '0;
         trial = '0;
         st_in = cur;
         for (int j = 0; j < STEP_BITS; j++) begin
            if (s * STEP_BITS + j < spcr_pkg::SQRT_STEPS) begin
               r_sh    = {st_in.rem, st_in.x[63:62]};
               trial   = {2'b00, st_in.root, 2'b01};
               st_in.x = {st_in.x[61:0], 2'b00};
               if (r_sh >= trial) begin
                  st_in.rem  = 34'(r_sh - trial);
                  st_in.root = {st_in.root[30:0], 1'b1};
               end else begin
                  st_in.rem  = r_sh[33:0];
                  st_in.root = {st_in.root[30:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[s] <= 1'b0;
         else valid_ff[s] <= cur_valid;
         st_ff[s]   <= st_in;
         pipe_ff[s] <= cur_pipe;
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_pipe  = pipe_ff[NST-1];
   assign out_len   = st_ff[NST-1].root;

endmodule

// ===== rtl/spcr_div.sv =====
// Pipelined restoring divider: three quotients m_i * 2^30 / len in parallel.
// Depends on spcr_pkg.
module spcr_div #(
   parameter int unsigned STEP_BITS = spcr_pkg::STEP_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  spcr_pkg::pipe_type   in_pipe,
   input  logic [31:0]          in_len,
   output logic                 out_valid,
   output spcr_pkg::carry_type  out_carry,
   output logic [2:0][30:0]     out_q
);

   localparam int unsigned NST = (spcr_pkg::DIV_STEPS + STEP_BITS - 1) / STEP_BITS;

   typedef struct packed {
      logic [31:0]      len;
      logic [2:0][31:0] r;
      logic [2:0][30:0] q;
   } dv_st_type;

   logic                 valid_ff [NST];
   dv_st_type            st_ff    [NST];
   spcr_pkg::carry_type  c_ff     [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic                cur_valid;
      dv_st_type           cur;
      dv_st_type           st_in;
      spcr_pkg::carry_type cur_c;

      if (s == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur       = '{len: in_len, r: in_pipe.m, q: '0};
         assign cur_c     = in_pipe.c;
      end else begin : g_rest
         assign cur_valid = valid_ff[s-1];
         assign cur       = st_ff[s-1];
         assign cur_c     = c_ff[s-1];
      end

      always_comb begin : step
         logic [32:0] r2;
         r2    = '0;
         st_in = cur;
         for (int j = 0; j < STEP_BITS; j++) begin
            if (s * STEP_BITS + j < spcr_pkg::DIV_STEPS) begin
               for (int i = 0; i < 3; i++) begin
                  // first step tests the integer bit, later ones shift in zeros
                  if (s * STEP_BITS + j == 0) r2 = {1'b0, st_in.r[i]};
                  else r2 = {st_in.r[i], 1'b0};
                  if (r2 >= {1'b0, st_in.len}) begin
                     st_in.r[i] = 32'(r2 - {1'b0, st_in.len});
                     st_in.q[i] = {st_in.q[i][29:0], 1'b1};
                  end else begin
                     st_in.r[i] = r2[31:0];
                     st_in.q[i] = {st_in.q[i][29:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[s] <= 1'b0;
         else valid_ff[s] <= cur_valid;
         st_ff[s] <= st_in;
         c_ff[s]  <= cur_c;
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_carry = c_ff[NST-1];
   assign out_q     = st_ff[NST-1].q;

endmodule

// ===== rtl/spcr_resp.sv =====
// Contact test and collision response: dot products, push-out, restitution,
// friction and saturation. Depends on spcr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spcr_resp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  spcr_pkg::carry_type  in_carry,
   input  logic [2:0][30:0]     in_q,
   input  logic [30:0]          radius,
   input  logic [16:0]          restit,
   input  logic [16:0]          frict,
   output logic                 out_valid,
   output logic [2:0][31:0]     out_pos,
   output logic [2:0][31:0]     out_vel,
   output logic                 out_contact
);

   // R0: signed unit normal, Q1.30
   logic                n0_valid_ff;
   spcr_pkg::carry_type c0_ff;
   logic [2:0][31:0]    n0_ff, n0_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (in_carry.zero) n0_in[i] = (i == 1) ? spcr_pkg::UNIT_ONE : '0;
         else if (in_carry.neg[i]) n0_in[i] = ~{1'b0, in_q[i]} + 32'd1;
         else n0_in[i] = {1'b0, in_q[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) n0_valid_ff <= 1'b0;
      else n0_valid_ff <= in_valid;
      c0_ff <= in_carry;
      n0_ff <= n0_in;
   end

   // R1: products for both dot products
   logic                v1_ff;
   spcr_pkg::carry_type c1_ff;
   logic [2:0][31:0]    n1_ff;
   logic signed [64:0]  pd1_ff [3];
   logic signed [63:0]  pv1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= n0_valid_ff;
      c1_ff <= c0_ff;
      n1_ff <= n0_ff;
      for (int i = 0; i < 3; i++) begin
         pd1_ff[i] <= 65'($signed(c0_ff.diff[i])) * 65'($signed(n0_ff[i]));
         pv1_ff[i] <= 64'($signed(c0_ff.vel[i])) * 64'($signed(n0_ff[i]));
      end
   end

   // R2: sums, floor shift by 30
   logic                v2_ff;
   spcr_pkg::carry_type c2_ff;
   logic [2:0][31:0]    n2_ff;
   logic signed [36:0]  dist2_ff;
   logic signed [35:0]  vn2_ff;
   logic signed [66:0]  dd;
   logic signed [65:0]  dv;

   assign dd = 67'(pd1_ff[0]) + 67'(pd1_ff[1]) + 67'(pd1_ff[2]);
   assign dv = 66'(pv1_ff[0]) + 66'(pv1_ff[1]) + 66'(pv1_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      c2_ff    <= c1_ff;
      n2_ff    <= n1_ff;
      dist2_ff <= $signed(dd[66:30]);
      vn2_ff   <= $signed(dv[65:30]);
   end

   // R3: contact test, penetration, restitution product
   logic                v3_ff;
   spcr_pkg::carry_type c3_ff;
   logic [2:0][31:0]    n3_ff;
   logic                contact3_ff;
   logic signed [37:0]  pen3_ff;
   logic signed [35:0]  vn3_ff;
   logic signed [54:0]  pe3_ff;
   logic signed [37:0]  r38;
   logic [16:0]         e_clamp;

   assign r38     = 38'($signed({1'b0, radius}));
   assign e_clamp = (restit > spcr_pkg::Q16_ONE) ? spcr_pkg::Q16_ONE : restit;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      c3_ff       <= c2_ff;
      n3_ff       <= n2_ff;
      contact3_ff <= 38'(dist2_ff) < r38;
      pen3_ff     <= r38 - 38'(dist2_ff);
      vn3_ff      <= vn2_ff;
      pe3_ff      <= 55'(-37'(vn2_ff)) * 55'($signed({1'b0, e_clamp}));
   end

   // R4: reflected normal speed
   logic                v4_ff;
   spcr_pkg::carry_type c4_ff;
   logic [2:0][31:0]    n4_ff;
   logic                contact4_ff;
   logic signed [37:0]  pen4_ff;
   logic signed [35:0]  vn4_ff;
   logic signed [39:0]  vr4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      c4_ff       <= c3_ff;
      n4_ff       <= n3_ff;
      contact4_ff <= contact3_ff;
      pen4_ff     <= pen3_ff;
      vn4_ff      <= vn3_ff;
      vr4_ff      <= vn3_ff[35] ? 40'($signed(pe3_ff[54:16])) : 40'(vn3_ff);
   end

   // R5: projections onto the normal
   logic                v5_ff;
   spcr_pkg::carry_type c5_ff;
   logic                contact5_ff;
   logic signed [69:0]  pm5_ff [3];
   logic signed [67:0]  vm5_ff [3];
   logic signed [71:0]  rm5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      c5_ff       <= c4_ff;
      contact5_ff <= contact4_ff;
      for (int i = 0; i < 3; i++) begin
         pm5_ff[i] <= 70'(pen4_ff) * 70'($signed(n4_ff[i]));
         vm5_ff[i] <= 68'(vn4_ff) * 68'($signed(n4_ff[i]));
         rm5_ff[i] <= 72'(vr4_ff) * 72'($signed(n4_ff[i]));
      end
   end

   // R6: pushed-out position, tangential velocity
   logic                v6_ff;
   spcr_pkg::carry_type c6_ff;
   logic                contact6_ff;
   logic signed [40:0]  pp6_ff [3];
   logic signed [38:0]  t6_ff  [3];
   logic signed [41:0]  rr6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      c6_ff       <= c5_ff;
      contact6_ff <= contact5_ff;
      for (int i = 0; i < 3; i++) begin
         pp6_ff[i] <= 41'($signed(c5_ff.pos[i])) + 41'($signed(pm5_ff[i][69:30]));
         t6_ff[i]  <= 39'($signed(c5_ff.vel[i])) - 39'($signed(vm5_ff[i][67:30]));
         rr6_ff[i] <= $signed(rm5_ff[i][71:30]);
      end
   end

   // R7: friction damping of the tangential part
   logic                v7_ff;
   spcr_pkg::carry_type c7_ff;
   logic                contact7_ff;
   logic signed [40:0]  pp7_ff [3];
   logic signed [41:0]  rr7_ff [3];
   logic signed [56:0]  td7_ff [3];
   logic [16:0]         f_clamp;
   logic [16:0]         damp;

   assign f_clamp = (frict > spcr_pkg::Q16_ONE) ? spcr_pkg::Q16_ONE : frict;
   assign damp    = spcr_pkg::Q16_ONE - f_clamp;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6_ff;
      c7_ff       <= c6_ff;
      contact7_ff <= contact6_ff;
      for (int i = 0; i < 3; i++) begin
         pp7_ff[i] <= pp6_ff[i];
         rr7_ff[i] <= rr6_ff[i];
         td7_ff[i] <= 57'(t6_ff[i]) * 57'($signed({1'b0, damp}));
      end
   end

   // R8: final sum, saturation, output register
   logic                v8_ff;
   logic [2:0][31:0]    pos8_ff, pos8_in;
   logic [2:0][31:0]    vel8_ff, vel8_in;
   logic                contact8_ff;
   logic signed [43:0]  vsum [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsum[i] = 44'(rr7_ff[i]) + 44'($signed(td7_ff[i][56:16]));
         pos8_in[i] = contact7_ff ? spcr_pkg::sat32(64'(pp7_ff[i])) : c7_ff.pos[i];
         vel8_in[i] = contact7_ff ? spcr_pkg::sat32(64'(vsum[i])) : c7_ff.vel[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else v8_ff <= v7_ff;
      pos8_ff     <= pos8_in;
      vel8_ff     <= vel8_in;
      contact8_ff <= contact7_ff;
   end

   assign out_valid   = v8_ff;
   assign out_pos     = pos8_ff;
   assign out_vel     = vel8_ff;
   assign out_contact = contact8_ff;

   // every unit normal component lies within [-1.0, 1.0] in Q1.30
   logic n0_in_range;

   always_comb begin
      n0_in_range = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (($signed(n0_ff[i]) > spcr_pkg::UNIT_ONE)
             || ($signed(n0_ff[i]) < -spcr_pkg::UNIT_ONE)) n0_in_range = 1'b0;
      end
   end

   `ASSERT_IMPLY(a_unit_range, clock, reset, n0_valid_ff, n0_in_range)

endmodule

// ===== rtl/sphere_plane_collision_resolve.sv =====
// Sphere-plane collision resolver.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. busy is high only during reset and the cycle after it, so
// a new transaction can be issued every cycle.
// Results come back in issue order on the rsp_ ports, qualified by
// rsp_strobe for exactly one cycle; there is no backpressure.
// Throughput is one transaction per cycle. The pipeline depth depends on
// STEP_BITS through the pipelined square root and the three-way restoring
// divider used to normalize the surface normal, each retiring STEP_BITS
// bits per stage.
// Registers (APB, word addresses 0x0, 0x4, 0x8): ball radius, restitution,
// friction; write them only while no transaction is in flight.
// Synchronous reset clears every in-flight transaction and restores the
// register defaults.
// Depends on spcr_pkg, spcr_front, spcr_sqrt, spcr_div, spcr_resp and
// assert_macros.svh.
`include "assert_macros.svh"
module sphere_plane_collision_resolve #(
   parameter int unsigned STEP_BITS = spcr_pkg::STEP_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [31:0]                 req_pos_x,
   input  logic [31:0]                 req_pos_y,
   input  logic [31:0]                 req_pos_z,
   input  logic [31:0]                 req_vel_x,
   input  logic [31:0]                 req_vel_y,
   input  logic [31:0]                 req_vel_z,
   input  logic [31:0]                 req_point_x,
   input  logic [31:0]                 req_point_y,
   input  logic [31:0]                 req_point_z,
   input  logic [31:0]                 req_normal_x,
   input  logic [31:0]                 req_normal_y,
   input  logic [31:0]                 req_normal_z,
   output logic                        rsp_strobe,
   output logic [31:0]                 rsp_new_pos_x,
   output logic [31:0]                 rsp_new_pos_y,
   output logic [31:0]                 rsp_new_pos_z,
   output logic [31:0]                 rsp_new_vel_x,
   output logic [31:0]                 rsp_new_vel_y,
   output logic [31:0]                 rsp_new_vel_z,
   output logic                        rsp_contact,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [spcr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int unsigned LATENCY = spcr_pkg::FRONT_STAGES
      + (spcr_pkg::SQRT_STEPS + STEP_BITS - 1) / STEP_BITS
      + (spcr_pkg::DIV_STEPS + STEP_BITS - 1) / STEP_BITS
      + spcr_pkg::RESP_STAGES;

   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // configuration registers
   logic [30:0]           radius_ff;
   logic [16:0]           restit_ff;
   logic [16:0]           frict_ff;
   spcr_pkg::reg_idx_type reg_idx;

   assign reg_idx = spcr_pkg::reg_idx_type'(paddr[3:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= spcr_pkg::RADIUS_RESET;
         restit_ff <= spcr_pkg::RESTIT_RESET;
         frict_ff  <= spcr_pkg::FRICT_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            spcr_pkg::REG_RADIUS:      radius_ff <= pwdata[30:0];
            spcr_pkg::REG_RESTITUTION: restit_ff <= pwdata[16:0];
            spcr_pkg::REG_FRICTION:    frict_ff  <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         spcr_pkg::REG_RADIUS:      prdata = {1'b0, radius_ff};
         spcr_pkg::REG_RESTITUTION: prdata = {15'd0, restit_ff};
         spcr_pkg::REG_FRICTION:    prdata = {15'd0, frict_ff};
         default:                   prdata = '0;
      endcase
   end

   // datapath
   logic                fr_valid;
   spcr_pkg::pipe_type  fr_pipe;
   logic [63:0]         fr_sum;
   logic                sq_valid;
   spcr_pkg::pipe_type  sq_pipe;
   logic [31:0]         sq_len;
   logic                dv_valid;
   spcr_pkg::carry_type dv_carry;
   logic [2:0][30:0]    dv_q;
   logic [2:0][31:0]    out_pos;
   logic [2:0][31:0]    out_vel;

   spcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pos    ({req_pos_z, req_pos_y, req_pos_x}),
      .in_vel    ({req_vel_z, req_vel_y, req_vel_x}),
      .in_pt     ({req_point_z, req_point_y, req_point_x}),
      .in_raw    ({req_normal_z, req_normal_y, req_normal_x}),
      .out_valid (fr_valid),
      .out_pipe  (fr_pipe),
      .out_sum   (fr_sum)
   );

   spcr_sqrt #(.STEP_BITS(STEP_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_pipe   (fr_pipe),
      .in_sum    (fr_sum),
      .out_valid (sq_valid),
      .out_pipe  (sq_pipe),
      .out_len   (sq_len)
   );

   spcr_div #(.STEP_BITS(STEP_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_pipe   (sq_pipe),
      .in_len    (sq_len),
      .out_valid (dv_valid),
      .out_carry (dv_carry),
      .out_q     (dv_q)
   );

   spcr_resp u_resp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_carry    (dv_carry),
      .in_q        (dv_q),
      .radius      (radius_ff),
      .restit      (restit_ff),
      .frict       (frict_ff),
      .out_valid   (rsp_strobe),
      .out_pos     (out_pos),
      .out_vel     (out_vel),
      .out_contact (rsp_contact)
   );

   assign rsp_new_pos_x = out_pos[0];
   assign rsp_new_pos_y = out_pos[1];
   assign rsp_new_pos_z = out_pos[2];
   assign rsp_new_vel_x = out_vel[0];
   assign rsp_new_vel_y = out_vel[1];
   assign rsp_new_vel_z = out_vel[2];

   `ASSERT_AFTER(a_result_follows, clock, reset, accept, LATENCY, rsp_strobe)
   `ASSERT_IMPLY(a_result_has_cause, clock, reset, rsp_strobe, $past(accept, LATENCY))

endmodule
